### rtl/tpc_frame_item_decoder_assert.svh
// Assertion macros for the frame item decoder.
`ifndef TPC_FRAME_ITEM_DECODER_ASSERT_SVH
`define TPC_FRAME_ITEM_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TFID_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfid assertion failed");

// Next-cycle implication, checked out of reset.
`define TFID_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfid assertion failed");

`endif

### rtl/tfid_pkg.sv
package tfid_pkg;

  localparam int BUCKETS  = 512;
  localparam int CHANNELS = 68;
  localparam int CHIPS    = 4;
  localparam int PAIRS    = (CHANNELS + 1) / 2;

  localparam int CHIP_W   = 2;
  localparam int CHAN_W   = 7;
  localparam int PAIR_W   = 6;
  localparam int BUCKET_W = 9;
  localparam int SAMPLE_W = 12;

  localparam logic [CHIP_W:0]   CHIPS_L   = (CHIP_W + 1)'(CHIPS);
  localparam logic [PAIR_W:0]   PAIRS_L   = (PAIR_W + 1)'(PAIRS);
  localparam logic [BUCKET_W:0] BUCKETS_L = (BUCKET_W + 1)'(BUCKETS);

  localparam logic [1:0] MODE_PARTIAL = 2'd1;
  localparam logic [1:0] MODE_FULL    = 2'd2;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  frame_mode;
    logic        start_of_frame;
    logic        last_word;
  } item_t;

  typedef struct packed {
    logic [CHIP_W-1:0]   chip;
    logic [PAIR_W-1:0]   pair;
    logic [BUCKET_W-1:0] bucket;
  } pos_t;

  typedef struct packed {
    logic take;
    logic sof;
    logic adv;
  } pos_ctl_t;

  typedef struct packed {
    logic [CHIP_W-1:0]   chip;
    logic [CHAN_W-1:0]   channel;
    logic [BUCKET_W-1:0] bucket;
    logic [SAMPLE_W-1:0] sample;
    logic                last_of_word;
    logic                frame_end;
  } rec_t;

endpackage

### rtl/tfid_pos.sv
module tfid_pos (
  input  logic              clk,
  input  logic              rst_n,
  input  tfid_pkg::pos_ctl_t ctl,
  output tfid_pkg::pos_t    pos
);

  tfid_pkg::pos_t cnt_r;
  tfid_pkg::pos_t cnt_nxt;
  tfid_pkg::pos_t eff;
  tfid_pkg::pos_t stepped;

  logic [tfid_pkg::CHIP_W:0]   chip_inc;
  logic [tfid_pkg::PAIR_W:0]   pair_inc;
  logic [tfid_pkg::BUCKET_W:0] bucket_inc;

  // start flag clears the position ahead of the word
  assign eff = ctl.sof ? '0 : cnt_r;
  assign pos = eff;

  assign chip_inc   = {1'b0, eff.chip} + 1'b1;
  assign pair_inc   = {1'b0, eff.pair} + 1'b1;
  assign bucket_inc = {1'b0, eff.bucket} + 1'b1;

  always_comb begin
    stepped = eff;
    if (chip_inc >= tfid_pkg::CHIPS_L) begin
      stepped.chip = '0;
      if (pair_inc >= tfid_pkg::PAIRS_L) begin
        stepped.pair = '0;
        if (bucket_inc >= tfid_pkg::BUCKETS_L) begin
          stepped.bucket = '0;
        end else begin
          stepped.bucket = bucket_inc[tfid_pkg::BUCKET_W-1:0];
        end
      end else begin
        stepped.pair = pair_inc[tfid_pkg::PAIR_W-1:0];
      end
    end else begin
      stepped.chip = chip_inc[tfid_pkg::CHIP_W-1:0];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.take) begin
      cnt_nxt = ctl.adv ? stepped : eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/tfid_unpack.sv
module tfid_unpack (
  input  tfid_pkg::item_t item,
  input  tfid_pkg::pos_t  pos,
  input  logic            second,
  output tfid_pkg::rec_t  rec
);

  logic [tfid_pkg::CHIP_W:0]   chip_inc;
  logic [tfid_pkg::PAIR_W:0]   pair_inc;
  logic [tfid_pkg::BUCKET_W:0] bucket_inc;
  logic                        at_end;
  logic [31:0]                 w;

  assign w          = item.word;
  assign chip_inc   = {1'b0, pos.chip} + 1'b1;
  assign pair_inc   = {1'b0, pos.pair} + 1'b1;
  assign bucket_inc = {1'b0, pos.bucket} + 1'b1;
  assign at_end     = (chip_inc >= tfid_pkg::CHIPS_L) && (pair_inc >= tfid_pkg::PAIRS_L) &&
                      (bucket_inc >= tfid_pkg::BUCKETS_L);

  always_comb begin
    case (item.frame_mode)
      tfid_pkg::MODE_PARTIAL: begin
        rec.chip         = w[7:6];
        rec.channel      = {w[5:0], w[15]};
        rec.bucket       = {w[14:8], w[23:22]};
        rec.sample       = {w[19:16], w[31:24]};
        rec.last_of_word = 1'b1;
        rec.frame_end    = item.last_word;
      end
      default: begin
        rec.chip         = pos.chip;
        rec.channel      = {pos.pair, second};
        rec.bucket       = pos.bucket;
        rec.sample       = second ? {w[19:16], w[31:24]} : {w[3:0], w[15:8]};
        rec.last_of_word = second;
        rec.frame_end    = second && at_end;
      end
    endcase
  end

endmodule

### rtl/tpc_frame_item_decoder.sv
// Channel  | Ports            | Contents
// input    | in_t*            | tdata word; tuser frame mode, start flag; tlast last word
// result   | out_t*           | tdata chip, channel, bucket, sample; tuser last of word;
//          |                  | tlast frame end
// One input register feeds one result register; partial mode takes one word per cycle while the result is not stalled.
// Full mode loads the shared result register once per sample, both samples of a word in turn.
// Modes 0 and 3 are dropped from the input register without using the result register.
// Synchronous active-low reset clears valids, phase and position counters.
// A stalled result holds; the input register still takes a word while it is empty.
`include "tpc_frame_item_decoder_assert.svh"

module tpc_frame_item_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] word
  input  logic [2:0]  in_tuser,   // [1:0] frame_mode, [2] start_of_frame
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [1:0] chip, [8:2] channel, [17:9] bucket, [29:18] sample
  output logic        out_tuser,  // last_of_word
  output logic        out_tlast   // frame_end
);

  logic              in_v_r;
  logic              in_v_nxt;
  tfid_pkg::item_t   item_r;
  logic              phase_r;
  logic              phase_nxt;
  logic              out_v_r;
  logic              out_v_nxt;
  tfid_pkg::rec_t    rec_r;
  tfid_pkg::rec_t    rec;
  tfid_pkg::pos_t    pos;
  tfid_pkg::pos_ctl_t pctl;

  logic is_part;
  logic is_full;
  logic out_free;
  logic load;
  logic consume;
  logic in_take;

  assign is_part  = item_r.frame_mode == tfid_pkg::MODE_PARTIAL;
  assign is_full  = item_r.frame_mode == tfid_pkg::MODE_FULL;
  assign out_free = !out_v_r || out_tready;
  assign load     = in_v_r && out_free && (is_part || is_full);
  assign consume  = in_v_r && (!(is_part || is_full) || (out_free && (is_part || phase_r)));
  assign in_tready = !in_v_r || consume;
  assign in_take  = in_tvalid && in_tready;

  assign pctl.take = consume;
  assign pctl.sof  = item_r.start_of_frame && in_v_r;
  assign pctl.adv  = is_full;

  tfid_pos u_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pctl),
    .pos   (pos)
  );

  tfid_unpack u_unpack (
    .item   (item_r),
    .pos    (pos),
    .second (phase_r),
    .rec    (rec)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (consume) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (in_v_r && out_free && is_full) begin
      phase_nxt = !phase_r;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      phase_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      phase_r <= phase_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.word           <= in_tdata;
      item_r.frame_mode     <= in_tuser[1:0];
      item_r.start_of_frame <= in_tuser[2];
      item_r.last_word      <= in_tlast;
    end
    if (load) begin
      rec_r <= rec;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, rec_r.sample, rec_r.bucket, rec_r.channel, rec_r.chip};
  assign out_tuser  = rec_r.last_of_word;
  assign out_tlast  = rec_r.frame_end;

  // second sample pending only for a held full-mode word
  `TFID_ASSERT_IMP(a_phase_full, phase_r, in_v_r && is_full)
  // a first-of-pair record on the output means its partner is still to come
  `TFID_ASSERT_IMP(a_first_pending, out_v_r && !rec_r.last_of_word, phase_r)
  // position counters stay inside the frame geometry
  `TFID_ASSERT_IMP(a_pos_range, !pctl.sof,
                   ({1'b0, pos.chip} < tfid_pkg::CHIPS_L) &&
                   ({1'b0, pos.pair} < tfid_pkg::PAIRS_L) &&
                   ({1'b0, pos.bucket} < tfid_pkg::BUCKETS_L))
  // a full-mode word leaves the input register only after both samples
  `TFID_ASSERT_NXT(a_full_two, in_v_r && is_full && !phase_r && out_free, in_v_r && phase_r)

endmodule
